// ===== design/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types and constants for the max-heap priority queue unit
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // built heap depth and derived widths
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = 7;
    localparam int IDX_W     = ADDR_W + 2;
    localparam int PRICE_W   = 32;
    localparam int TAG_W     = 32;
    localparam int CAP_RESET = 64;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXTRACTED = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // heap entry, price in the high half
    typedef struct packed {
        logic signed [PRICE_W-1:0] price;
        logic [TAG_W-1:0]          tag;
    } t_entry;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_X_ROOT,
        S_X_LAST,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DONE
    } t_state;

    // read address source
    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    // write data source, the address is always the hole position
    typedef enum logic [1:0] {
        WR_ITEM,
        WR_RDATA,
        WR_LEFT
    } t_wr_sel;

    // hole position update
    typedef enum logic [1:0] {
        POS_HOLD,
        POS_PARENT,
        POS_LEFT,
        POS_RIGHT
    } t_pos_sel;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_pos_sel pos_sel;
        logic     cap_root;
        logic     load_item;
        logic     load_left;
        logic     load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_up;       // incoming insert that fits
        logic go_down;     // incoming extract on a non-empty heap
        logic cnt_zero;
        logic pos_zero;
        logic has_left;
        logic has_right;
        logic rd_lt_item;  // read entry smaller than the moving item
        logic item_lt_rd;
        logic item_lt_left;
        logic left_lt_rd;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/max_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// binary max-heap of price/tag entries with insert and extract-max
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An insert climbs one level at a time
// (read parent, compare and move); an extract reads the root and the last
// entry, then sinks one level at a time (read left child, read right child,
// move), each step limited by the single read port of the entry memory.
// Rejected inserts and extracts from an empty heap skip the walk. A finished
// result sits in an output register, so the next beat is taken while the
// previous result waits. The moving entry is held in a register and only
// displaced entries are written back, one memory write per level. The
// capacity register may be written only while the unit is idle; it saturates
// at the built depth of 64 entries.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // capacity limit register
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    // operation input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // price[31:0], tag[63:32]
    input  logic        s_axis_tuser,   // op: 0 insert, 1 extract
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // out_price[31:0], out_tag[63:32],
                                        // count[70:64], zero fill [71]
    output logic [1:0]  m_axis_tuser    // status
);
    import mhpq_pkg::*;

    t_dp_cmd                   cmd;
    t_dp_status                st;
    logic [1:0]                out_status;
    logic signed [PRICE_W-1:0] out_price;
    logic [TAG_W-1:0]          out_tag;
    logic [CNT_W-1:0]          out_count;

    // sequencer: walks the heap one level at a time
    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // memory, counters, comparators and the output register
    mhpq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_in_op       (s_axis_tuser),
        .i_in_price    ($signed(s_axis_tdata[31:0])),
        .i_in_tag      (s_axis_tdata[63:32]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (out_status),
        .o_price       (out_price),
        .o_tag         (out_tag),
        .o_count       (out_count)
    );

    // pack the result beat
    assign m_axis_tdata = {1'b0, out_count, out_tag, out_price};
    assign m_axis_tuser = out_status;

endmodule

// ===== design/mhpq_datapath.sv =====
// ----------------------------------------------------------------------------
// mhpq_datapath
// entry memory, hole pointer, count, comparators and result registers
// ----------------------------------------------------------------------------
module mhpq_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mhpq_pkg::t_dp_cmd                 i_cmd,
    output mhpq_pkg::t_dp_status              o_st,
    input  logic                              i_in_op,
    input  logic signed [mhpq_pkg::PRICE_W-1:0] i_in_price,
    input  logic [mhpq_pkg::TAG_W-1:0]        i_in_tag,
    input  logic                              i_cfg_wr_en,
    input  logic [mhpq_pkg::CNT_W-1:0]        i_cfg_wr_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [1:0]                        o_status,
    output logic signed [mhpq_pkg::PRICE_W-1:0] o_price,
    output logic [mhpq_pkg::TAG_W-1:0]        o_tag,
    output logic [mhpq_pkg::CNT_W-1:0]        o_count
);
    import mhpq_pkg::*;

    t_entry r_mem [DEPTH];

    t_entry              r_rd_data;
    t_entry              r_item;
    t_entry              r_left;
    logic [ADDR_W-1:0]   r_pos;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_cap;
    t_status             r_res_status;
    logic signed [PRICE_W-1:0] r_res_price;
    logic [TAG_W-1:0]    r_res_tag;
    logic                r_out_valid;
    t_status             r_out_status;
    logic signed [PRICE_W-1:0] r_out_price;
    logic [TAG_W-1:0]    r_out_tag;
    logic [CNT_W-1:0]    r_out_count;

    logic [ADDR_W-1:0]   parent_addr;
    logic [IDX_W-1:0]    left_idx;
    logic [IDX_W-1:0]    right_idx;
    logic [IDX_W-1:0]    count_idx;
    logic [ADDR_W-1:0]   rd_addr;
    t_entry              wr_data;
    logic                full;
    logic                empty;
    logic [ADDR_W-1:0]   n_pos;

    assign parent_addr = (r_pos - ADDR_W'(1)) >> 1;
    assign left_idx    = {1'b0, r_pos, 1'b0} + IDX_W'(1);
    assign right_idx   = {1'b0, r_pos, 1'b0} + IDX_W'(2);
    assign count_idx   = IDX_W'(r_count);

    // limit saturates at the built depth, a zero limit rejects every insert
    assign full  = (r_count >= r_cap) || (r_count >= CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_ROOT:   rd_addr = '0;
            RD_LAST:   rd_addr = r_count[ADDR_W-1:0];
            RD_PARENT: rd_addr = parent_addr;
            RD_LEFT:   rd_addr = left_idx[ADDR_W-1:0];
            RD_RIGHT:  rd_addr = right_idx[ADDR_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_ITEM:  wr_data = r_item;
            WR_RDATA: wr_data = r_rd_data;
            WR_LEFT:  wr_data = r_left;
            default:  wr_data = r_item;
        endcase
    end

    always_comb begin
        unique case (i_cmd.pos_sel)
            POS_HOLD:   n_pos = r_pos;
            POS_PARENT: n_pos = parent_addr;
            POS_LEFT:   n_pos = left_idx[ADDR_W-1:0];
            POS_RIGHT:  n_pos = right_idx[ADDR_W-1:0];
            default:    n_pos = r_pos;
        endcase
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item.price <= i_in_price;
            r_item.tag   <= i_in_tag;
            r_res_tag    <= '0;
            if (i_in_op) begin
                r_res_status <= empty ? ST_EMPTY : ST_EXTRACTED;
                r_res_price  <= empty ? -PRICE_W'(1) : '0;
            end else begin
                r_res_status <= full ? ST_FULL : ST_INSERTED;
                r_res_price  <= '0;
            end
        end else begin
            if (i_cmd.load_item) begin
                r_item <= r_rd_data;
            end
            if (i_cmd.cap_root) begin
                r_res_price <= r_rd_data.price;
                r_res_tag   <= r_rd_data.tag;
            end
        end
        if (i_cmd.load_left) begin
            r_left <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_price  <= r_res_price;
            r_out_tag    <= r_res_tag;
            r_out_count  <= r_count;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CNT_W'(CAP_RESET);
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                if (!i_in_op && !full) begin
                    r_pos   <= r_count[ADDR_W-1:0];
                    r_count <= r_count + CNT_W'(1);
                end else if (i_in_op && !empty) begin
                    r_pos   <= '0;
                    r_count <= r_count - CNT_W'(1);
                end
            end else begin
                r_pos <= n_pos;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_st.go_up        = !i_in_op && !full;
        o_st.go_down      = i_in_op && !empty;
        o_st.cnt_zero     = empty;
        o_st.pos_zero     = (r_pos == '0);
        o_st.has_left     = left_idx < count_idx;
        o_st.has_right    = right_idx < count_idx;
        o_st.rd_lt_item   = r_rd_data.price < r_item.price;
        o_st.item_lt_rd   = r_item.price < r_rd_data.price;
        o_st.item_lt_left = r_item.price < r_left.price;
        o_st.left_lt_rd   = r_left.price < r_rd_data.price;
        o_st.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_price     = r_out_price;
    assign o_tag       = r_out_tag;
    assign o_count     = r_out_count;

endmodule

// ===== design/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl
// sequencer for sift-up and sift-down over the entry memory
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  mhpq_pkg::t_dp_status   i_st,
    output mhpq_pkg::t_dp_cmd      o_cmd
);
    import mhpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.rd_sel    = RD_ROOT;
        o_cmd.wr_en     = 1'b0;
        o_cmd.wr_sel    = WR_ITEM;
        o_cmd.pos_sel   = POS_HOLD;
        o_cmd.cap_root  = 1'b0;
        o_cmd.load_item = 1'b0;
        o_cmd.load_left = 1'b0;
        o_cmd.load_out  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.go_up) begin
                        n_state = S_UP;
                    end else if (i_st.go_down) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_ROOT;
                        n_state      = S_X_ROOT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_UP: begin
                if (i_st.pos_zero) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_ITEM;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PARENT;
                    n_state      = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_st.rd_lt_item) begin
                    // parent moves down into the hole
                    o_cmd.wr_sel  = WR_RDATA;
                    o_cmd.pos_sel = POS_PARENT;
                    n_state       = S_UP;
                end else begin
                    o_cmd.wr_sel = WR_ITEM;
                    n_state      = S_DONE;
                end
            end
            S_X_ROOT: begin
                o_cmd.cap_root = 1'b1;
                if (i_st.cnt_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                    n_state      = S_X_LAST;
                end
            end
            S_X_LAST: begin
                o_cmd.load_item = 1'b1;
                n_state         = S_DN;
            end
            S_DN: begin
                if (i_st.has_left) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LEFT;
                    n_state      = S_DN_L;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_ITEM;
                    n_state      = S_DONE;
                end
            end
            S_DN_L: begin
                o_cmd.load_left = 1'b1;
                if (i_st.has_right) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_RIGHT;
                    n_state      = S_DN_R;
                end else if (i_st.item_lt_rd) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WR_RDATA;
                    o_cmd.pos_sel = POS_LEFT;
                    n_state       = S_DN;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_ITEM;
                    n_state      = S_DONE;
                end
            end
            S_DN_R: begin
                o_cmd.wr_en = 1'b1;
                // right wins only if strictly above the best so far
                if (i_st.item_lt_left ? i_st.left_lt_rd : i_st.item_lt_rd) begin
                    o_cmd.wr_sel  = WR_RDATA;
                    o_cmd.pos_sel = POS_RIGHT;
                    n_state       = S_DN;
                end else if (i_st.item_lt_left) begin
                    o_cmd.wr_sel  = WR_LEFT;
                    o_cmd.pos_sel = POS_LEFT;
                    n_state       = S_DN;
                end else begin
                    o_cmd.wr_sel = WR_ITEM;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/max_heap_priority_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit_tb
// self-checking bench for the price-keyed max-heap priority queue
// ----------------------------------------------------------------------------
// Drives insert and extract beats into the queue and keeps its own shadow
// heap, which works out the status, price, tag and count of every result.
// A short directed run hits the empty heap, extreme prices, equal prices and
// capacity changes below the current count. Random phases follow, each with
// its own capacity (zero and saturated values included) and mix of inserts
// and extracts. Both stream sides idle in random bursts except at the end.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit_tb;

    import mhpq_pkg::*;

    // operation codes carried on the input tuser
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // generous cycle budget, worst case is well under a tenth of it
    localparam int unsigned CYCLE_LIMIT = 400000;

    // one result beat split into its fields
    typedef struct packed {
        t_status                   status;
        logic signed [PRICE_W-1:0] price;
        logic [TAG_W-1:0]          tag;
        logic [CNT_W-1:0]          count;
    } t_outcome;

    // shadow heap plus the queue of outcomes still owed by the unit
    class heap_scoreboard;
        logic signed [PRICE_W-1:0] prices [DEPTH];
        logic [TAG_W-1:0]          tags [DEPTH];
        int unsigned               held;
        logic [CNT_W-1:0]          capacity;
        t_outcome                  owed[$];
        int unsigned               mismatches;
        int unsigned               status_seen [4];

        function new();
            held       = 0;
            capacity   = CNT_W'(CAP_RESET);
            mismatches = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [PRICE_W-1:0] p;
            logic [TAG_W-1:0]          t;
            p = prices[a];
            t = tags[a];
            prices[a] = prices[b];
            tags[a]   = tags[b];
            prices[b] = p;
            tags[b]   = t;
        endfunction

        // climb while the parent is strictly cheaper
        function void climb(int unsigned pos);
            int unsigned parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (!(prices[parent] < prices[pos])) break;
                swap_slots(pos, parent);
                pos = parent;
            end
        endfunction

        // sink toward the larger child, left wins a tie
        function void sink(int unsigned pos, int unsigned n);
            int unsigned best;
            int unsigned left;
            int unsigned right;
            forever begin
                best  = pos;
                left  = 2 * pos + 1;
                right = 2 * pos + 2;
                if (left < n && prices[best] < prices[left]) best = left;
                if (right < n && prices[best] < prices[right]) best = right;
                if (best == pos) break;
                swap_slots(pos, best);
                pos = best;
            end
        endfunction

        // apply one accepted operation and queue the outcome it must produce
        function void note_op(logic op, logic signed [PRICE_W-1:0] price,
                              logic [TAG_W-1:0] tag);
            t_outcome    res;
            int unsigned limit;
            limit     = (capacity < DEPTH) ? capacity : DEPTH;
            res.price = '0;
            res.tag   = '0;
            if (op == OP_INSERT) begin
                if (held >= limit) begin
                    res.status = ST_FULL;
                end else begin
                    prices[held] = price;
                    tags[held]   = tag;
                    climb(held);
                    held++;
                    res.status = ST_INSERTED;
                end
            end else if (held == 0) begin
                res.status = ST_EMPTY;
                res.price  = -1;
            end else begin
                res.price  = prices[0];
                res.tag    = tags[0];
                held--;
                prices[0]  = prices[held];
                tags[0]    = tags[held];
                sink(0, held);
                res.status = ST_EXTRACTED;
            end
            res.count = CNT_W'(held);
            status_seen[res.status]++;
            owed.push_back(res);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
        endtask

        task check_result(t_outcome got);
            t_outcome want;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending, status %s",
                                          got.status.name()));
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %s, wanted %s",
                                          got.status.name(), want.status.name()));
            if (got.price !== want.price)
                report_mismatch($sformatf("price %0d, wanted %0d", got.price, want.price));
            if (got.tag !== want.tag)
                report_mismatch($sformatf("tag %h, wanted %h", got.tag, want.tag));
            if (got.count !== want.count)
                report_mismatch($sformatf("count %0d, wanted %0d", got.count, want.count));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [6:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // price[31:0], tag[63:32]
    logic        s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;   // out_price[31:0], out_tag[63:32], count[70:64]
    logic [1:0]  m_axis_tuser;   // status

    heap_scoreboard board = new();

    bit          gaps_on = 1'b1;   // random idling on both sides
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    max_heap_priority_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.owed.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: check each taken beat, then pick the next ready level
    always @(posedge i_clk) begin
        t_outcome got;
        if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.status = t_status'(m_axis_tuser);
            got.price  = m_axis_tdata[31:0];
            got.tag    = m_axis_tdata[63:32];
            got.count  = m_axis_tdata[70:64];
            board.check_result(got);
        end
        // stalls come in bursts of random length
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one input beat, optionally preceded by an idle burst; valid stays high
    // after the handshake so back-to-back beats need no second assignment
    task automatic send_op(logic op, logic signed [PRICE_W-1:0] price,
                           logic [TAG_W-1:0] tag);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {tag, price};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        board.note_op(op, price, tag);
    endtask

    // drop valid, wait out every owed result and let the unit settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] cap);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.capacity = cap;
    endtask

    // mostly full-range prices, with extremes and a narrow band for ties
    function automatic logic signed [PRICE_W-1:0] pick_price();
        logic signed [PRICE_W-1:0] p;
        case ($urandom_range(0, 9))
            0:       p = 32'sh7fff_ffff;
            1:       p = 32'sh8000_0000;
            2, 3, 4: p = $signed(PRICE_W'($urandom_range(0, 8))) - 4;
            default: p = $urandom();
        endcase
        return p;
    endfunction

    task automatic run_phase(logic [CNT_W-1:0] cap, int unsigned insert_pct,
                             int unsigned beats);
        set_capacity(cap);
        repeat (beats) begin
            if ($urandom_range(1, 100) <= insert_pct)
                send_op(OP_INSERT, pick_price(), $urandom());
            else
                send_op(OP_EXTRACT, pick_price(), $urandom());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= OP_INSERT;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty heap straight after reset, at the reset capacity
        send_op(OP_EXTRACT, 32'sd0, 32'hffff_ffff);
        // extreme prices and tags, then a run of equal prices
        send_op(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
        send_op(OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
        send_op(OP_INSERT, 32'sd5, 32'd1);
        send_op(OP_INSERT, 32'sd5, 32'd2);
        send_op(OP_INSERT, 32'sd5, 32'd3);
        send_op(OP_INSERT, -32'sd1, 32'ha5a5_a5a5);
        send_op(OP_INSERT, 32'sd0, 32'h5a5a_5a5a);
        // drain in order, ties come out by heap position
        repeat (7) send_op(OP_EXTRACT, 32'sd0, 32'd0);
        send_op(OP_EXTRACT, 32'sd0, 32'd0);

        // capacity dropped below the count: inserts bounce until it falls
        send_op(OP_INSERT, 32'sd10, 32'd10);
        send_op(OP_INSERT, 32'sd30, 32'd30);
        send_op(OP_INSERT, 32'sd20, 32'd20);
        set_capacity(7'd1);
        send_op(OP_INSERT, 32'sd99, 32'd99);
        send_op(OP_EXTRACT, 32'sd0, 32'd0);
        send_op(OP_INSERT, 32'sd98, 32'd98);
        send_op(OP_EXTRACT, 32'sd0, 32'd0);
        send_op(OP_EXTRACT, 32'sd0, 32'd0);
        send_op(OP_INSERT, 32'sd97, 32'd97);
        send_op(OP_INSERT, 32'sd96, 32'd96);

        // zero capacity rejects every insert
        set_capacity(7'd0);
        send_op(OP_INSERT, 32'sd1, 32'd1);
        send_op(OP_EXTRACT, 32'sd0, 32'd0);

        // random phases: saturated capacity with heavy inserts fills all 64
        run_phase(7'd127, 90, 90);
        run_phase(7'd64, 35, 60);
        run_phase(7'd1, 50, 40);
        run_phase(7'd0, 50, 20);
        run_phase(7'd2, 60, 40);
        run_phase(CNT_W'($urandom_range(4, 63)), 60, 80);
        run_phase(7'd64, 50, 90);
        run_phase(7'd3, 50, 40);
        // closing stretch without any idling
        set_capacity(7'd127);
        gaps_on = 1'b0;
        run_phase(7'd127, 70, 100);

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (board.owed.size() != 0)
            board.report_mismatch($sformatf("%0d results never arrived",
                                            board.owed.size()));

        $display("covered %0d inserts, %0d rejected as full, %0d extracts, %0d from empty",
                 board.status_seen[ST_INSERTED], board.status_seen[ST_FULL],
                 board.status_seen[ST_EXTRACTED], board.status_seen[ST_EMPTY]);
        $display("capacities 0, 1, 2, 3, 64, 127 and one random value; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mhpq_pkg.sv
design/mhpq_datapath.sv
design/mhpq_ctrl.sv
design/max_heap_priority_queue_unit.sv
tb/max_heap_priority_queue_unit_tb.sv
